/* src/pfe_pkg.sv */
// Package for the postfix expression evaluator: payload structs, token and
// status codes, operator characters, the arithmetic request type and FSM states.
// No dependencies.
package pfe_pkg;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_APPLY = 2'd1,
		ACT_END   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FEW      = 3'd1,
		STAT_DIVZERO  = 3'd2,
		STAT_ILLEGAL  = 3'd3,
		STAT_MANY     = 3'd4,
		STAT_EMPTY    = 3'd5,
		STAT_OVERFLOW = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		AOP_ADD = 2'd0,
		AOP_SUB = 2'd1,
		AOP_MUL = 2'd2,
		AOP_DIV = 2'd3
	} arith_op_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_WAIT = 2'd2
	} state_t;

	localparam logic [7:0] CHAR_ADD = 8'h2B;
	localparam logic [7:0] CHAR_SUB = 8'h2D;
	localparam logic [7:0] CHAR_MUL = 8'h2A;
	localparam logic [7:0] CHAR_DIV = 8'h2F;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] number;
		logic [7:0]         operator_char;
	} token_t;

	typedef struct packed {
		logic signed [31:0] value;
		status_t            status;
	} result_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} arith_req_t;

endpackage

/* src/postfix_expression_evaluator.sv */
// Top level of the postfix expression evaluator: token FSM, stack pointer,
// error latch and result register. Depends on pfe_pkg, pfe_stack_ram, pfe_arith.
//
// Usage:
// Tokens arrive on the token channel (token_valid/token_ready, payload token)
// and one result item leaves on the result channel (result_valid/result_ready,
// payload result) for every end token. Push and ignored tokens finish in the
// cycle they are accepted, so one can be taken every cycle while no operator
// is in progress. An operator reads the first operand from the stack memory
// (a registered read) while the top of the stack is held in a register; add
// and subtract then finish in the execute state, multiply waits for the
// registered product, and divide for the restoring divider that retires one
// quotient bit per cycle. An end token is done in the cycle it is accepted
// and its result is shown from the next cycle. The result sits in an output
// register, so later tokens keep flowing while the receiver stalls; only a
// further end token waits until the pending result is taken. Reset clears the
// stack count, the latched error and the result valid flag; the stack memory
// itself is not cleared, since only entries below the count are ever read.
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             token_valid,
	output logic             token_ready,
	input  pfe_pkg::token_t  token,
	output logic             result_valid,
	input  logic             result_ready,
	output pfe_pkg::result_t result
);
	import pfe_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t             state_q, state_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	status_t            err_q, err_d;
	logic signed [31:0] top_q, top_d;
	arith_op_t          op_q, op_d;
	result_t            result_q;
	logic               result_valid_q;

	logic               out_free;
	logic               accept;
	logic               out_load;
	result_t            out_d;
	logic [CW-1:0]      below_cnt;
	logic [AW-1:0]      below_idx;

	logic               we;
	logic [AW-1:0]      waddr;
	logic signed [31:0] wdata;
	logic               re;
	logic signed [31:0] rdata_q;

	arith_req_t         req;
	logic               arith_done;
	logic signed [31:0] arith_res;
	logic signed [32:0] sum;
	logic signed [31:0] addsub_res;

	// Entry just below the top of the stack: the first operand of an operator
	// and the slot that receives its result.
	assign below_cnt = cnt_q - CW'(2);
	assign below_idx = below_cnt[AW-1:0];
	assign out_free  = !result_valid_q || result_ready;
	assign accept    = token_valid && token_ready;

	pfe_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (re),
		.raddr   (below_idx),
		.rdata_q (rdata_q)
	);

	pfe_arith #(
		.FRAC_BITS (FRAC_BITS)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (rdata_q),
		.b      (top_q),
		.done   (arith_done),
		.result (arith_res)
	);

	// Saturating add and subtract on a 33-bit sum.
	always_comb begin
		if (op_q == AOP_SUB) begin
			sum = {rdata_q[31], rdata_q} - {top_q[31], top_q};
		end else begin
			sum = {rdata_q[31], rdata_q} + {top_q[31], top_q};
		end
		if (sum[32] != sum[31]) begin
			addsub_res = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			addsub_res = sum[31:0];
		end
	end

	// The FSM handles one operator at a time, so a read of the stack memory
	// never overlaps a write to the same entry and no forwarding is needed.
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		err_d       = err_q;
		top_d       = top_q;
		op_d        = op_q;
		we          = 1'b0;
		waddr       = below_idx;
		wdata       = token.number;
		re          = 1'b0;
		req         = '0;
		out_load    = 1'b0;
		out_d       = '{value: 32'sd0, status: STAT_OK};
		token_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				token_ready = (token.action != ACT_END) || out_free;
				if (accept) begin
					unique case (token.action)
						ACT_PUSH: begin
							if (err_q == STAT_OK) begin
								if (cnt_q == CW'(STACK_DEPTH)) begin
									err_d = STAT_OVERFLOW;
								end else begin
									we    = 1'b1;
									waddr = cnt_q[AW-1:0];
									top_d = token.number;
									cnt_d = cnt_q + CW'(1);
								end
							end
						end
						ACT_APPLY: begin
							if (err_q == STAT_OK) begin
								if (cnt_q < CW'(2)) begin
									err_d = STAT_FEW;
								end else begin
									unique case (token.operator_char)
										CHAR_ADD: begin
											re      = 1'b1;
											op_d    = AOP_ADD;
											state_d = S_EXEC;
										end
										CHAR_SUB: begin
											re      = 1'b1;
											op_d    = AOP_SUB;
											state_d = S_EXEC;
										end
										CHAR_MUL: begin
											re      = 1'b1;
											op_d    = AOP_MUL;
											state_d = S_EXEC;
										end
										CHAR_DIV: begin
											if (top_q == 32'sd0) begin
												err_d = STAT_DIVZERO;
											end else begin
												re      = 1'b1;
												op_d    = AOP_DIV;
												state_d = S_EXEC;
											end
										end
										default: begin
											err_d = STAT_ILLEGAL;
										end
									endcase
								end
							end
						end
						ACT_END: begin
							out_load = 1'b1;
							if (err_q != STAT_OK) begin
								out_d.status = err_q;
							end else if (cnt_q == CW'(0)) begin
								out_d.status = STAT_EMPTY;
							end else if (cnt_q == CW'(1)) begin
								out_d.value = top_q;
							end else begin
								out_d.status = STAT_MANY;
							end
							cnt_d = '0;
							err_d = STAT_OK;
						end
						ACT_NONE: begin
						end
					endcase
				end
			end
			S_EXEC: begin
				// The first operand is now out of the memory.
				unique case (op_q)
					AOP_ADD, AOP_SUB: begin
						we      = 1'b1;
						wdata   = addsub_res;
						top_d   = addsub_res;
						cnt_d   = cnt_q - CW'(1);
						state_d = S_IDLE;
					end
					AOP_MUL: begin
						req.start = 1'b1;
						state_d   = S_WAIT;
					end
					AOP_DIV: begin
						req.start  = 1'b1;
						req.is_div = 1'b1;
						state_d    = S_WAIT;
					end
				endcase
			end
			S_WAIT: begin
				if (arith_done) begin
					we      = 1'b1;
					wdata   = arith_res;
					top_d   = arith_res;
					cnt_d   = cnt_q - CW'(1);
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			err_q          <= STAT_OK;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		op_q  <= op_d;
		if (out_load) begin
			result_q <= out_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* src/pfe_stack_ram.sv */
// Operand stack storage: one write port and one read port, read data
// registered in the cycle after the read is issued. Depends on nothing.
module pfe_stack_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic signed [31:0]  wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic signed [31:0]  rdata_q
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

/* src/pfe_arith.sv */
// Multiply and divide unit for signed fixed-point operands with saturation.
// Multiply takes one registered product; divide is restoring, one bit a cycle.
// Depends on pfe_pkg.
module pfe_arith #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pfe_pkg::arith_req_t req,
	input  logic signed [31:0]  a,
	input  logic signed [31:0]  b,
	output logic                done,
	output logic signed [31:0]  result
);
	import pfe_pkg::*;

	localparam int QW = 32 + FRAC_BITS;
	localparam int NW = $clog2(QW);

	logic [63:0]    prod_q;
	logic           mul_done_q;
	logic           div_busy_q;
	logic           div_done_q;
	logic [NW-1:0]  iter_q;
	logic [QW-1:0]  quo_q;
	logic [32:0]    rem_q;
	logic [31:0]    dvsr_q;
	logic           neg_q;
	logic [31:0]    mag_a;
	logic [31:0]    mag_b;
	logic [32:0]    rem_shift;
	logic [32:0]    rem_diff;
	logic           fits;
	logic           last_iter;

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? (32'd0 - x) : x;
	endfunction

	// Apply the sign to a magnitude and clamp to the 32-bit signed range.
	function automatic logic signed [31:0] sat_mag(input logic [63:0] m, input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			r = (m > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : (32'd0 - m[31:0]);
		end else begin
			r = (m > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
		end
		return r;
	endfunction

	assign mag_a     = mag32(a);
	assign mag_b     = mag32(b);
	assign rem_shift = {rem_q[31:0], quo_q[QW-1]};
	assign rem_diff  = rem_shift - {1'b0, dvsr_q};
	assign fits      = rem_shift >= {1'b0, dvsr_q};
	assign last_iter = iter_q == NW'(QW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_done_q <= 1'b0;
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			iter_q     <= '0;
		end else begin
			mul_done_q <= req.start && !req.is_div;
			div_done_q <= div_busy_q && last_iter;
			if (req.start && req.is_div) begin
				div_busy_q <= 1'b1;
				iter_q     <= '0;
			end else if (div_busy_q) begin
				iter_q <= iter_q + NW'(1);
				if (last_iter) begin
					div_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= a[31] ^ b[31];
			if (req.is_div) begin
				quo_q  <= QW'(mag_a) << FRAC_BITS;
				rem_q  <= '0;
				dvsr_q <= mag_b;
			end else begin
				prod_q <= {32'd0, mag_a} * {32'd0, mag_b};
			end
		end else if (div_busy_q) begin
			quo_q <= {quo_q[QW-2:0], fits};
			rem_q <= fits ? rem_diff : rem_shift;
		end
	end

	assign done   = mul_done_q || div_done_q;
	assign result = mul_done_q ? sat_mag(prod_q >> FRAC_BITS, neg_q)
	                           : sat_mag(64'(quo_q), neg_q);

endmodule

/* src/pfe_checker.sv */
// Port-level checker for the postfix expression evaluator, bound to the top
// level. Depends on pfe_pkg and postfix_expression_evaluator.
module pfe_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             token_valid,
	input logic             token_ready,
	input pfe_pkg::token_t  token,
	input logic             result_valid,
	input logic             result_ready,
	input pfe_pkg::result_t result
);
	import pfe_pkg::*;

	// A stalled result item holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result item changed while stalled");

	// A result item appears only after an end token was taken.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |->
			$past(token_valid && token_ready && token.action == ACT_END))
		else $error("result item without an end token");

	// A failed expression always reports zero.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != STAT_OK |-> result.value == 32'sd0)
		else $error("nonzero value with an error status");

	// An end token is held off while the previous result is still waiting.
	a_end_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token.action == ACT_END && result_valid && !result_ready
			|-> !token_ready)
		else $error("end token taken while the result register is full");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.token_valid  (token_valid),
	.token_ready  (token_ready),
	.token        (token),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

/* verif/postfix_expression_evaluator_test.sv */
// Self-checking testbench for the postfix expression evaluator: directed and random
// token streams, a cycle-free prediction of every end-of-expression result, stalls.
// Depends on pfe_pkg and postfix_expression_evaluator from the src folder.
module postfix_expression_evaluator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pfe_pkg::*;

	localparam int STACK_DEPTH  = 16;
	localparam int FRAC_BITS    = 16;
	// A divide is the slowest token; it sets how long the end of the run waits.
	localparam int DRAIN_CYCLES = 35 + FRAC_BITS + 16;
	// Cycles with no handshake on either channel before the run is abandoned.
	// The longest expected quiet stretch is the output hold-off below.
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_GOAL  = 1450;
	localparam int TAIL_ITEMS   = 100;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     token_valid;
	logic     token_ready;
	token_t   token;
	logic     result_valid;
	logic     result_ready;
	result_t  result;

	postfix_expression_evaluator #(
		.STACK_DEPTH(STACK_DEPTH),
		.FRAC_BITS  (FRAC_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token       (token),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #1ns clk = ~clk;

	// Predicted calculator state. It advances when a token is accepted, so it
	// is always the state the block will reach once its work is done.
	logic signed [31:0] calc_stack [STACK_DEPTH];
	int                 calc_depth;
	status_t            calc_error;

	// Results predicted for end tokens, oldest first.
	result_t pending_results [$];

	int  mismatch_count;
	int  items_sent;
	int  results_checked;
	int  status_seen [8];
	int  idle_cycles;

	// Knobs shared between the test tasks and the receiver process.
	bit  tx_idle_on;
	bit  rx_idle_on;
	int  hold_left;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("ERROR %0t: %s", $realtime, what);
	endtask

	function automatic logic signed [31:0] saturate(input longint x);
		if (x > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648)
			return 32'sh8000_0000;
		return x[31:0];
	endfunction

	// Pops the divisor or second operand (top) and the first operand below it.
	// Multiply and divide work on magnitudes so that both truncate toward zero;
	// the sign is put back before saturation.
	task automatic apply_operator(input logic [7:0] op);
		logic signed [31:0]  lhs;
		logic signed [31:0]  rhs;
		longint unsigned     lhs_mag;
		longint unsigned     rhs_mag;
		longint unsigned     mag_result;
		longint              exact;
		bit                  negative;
		if (calc_depth < 2) begin
			// Checked before the operator, so a bad character here still counts as
			// too few operands.
			calc_error = STAT_FEW;
			return;
		end
		rhs      = calc_stack[calc_depth - 1];
		lhs      = calc_stack[calc_depth - 2];
		negative = lhs[31] ^ rhs[31];
		lhs_mag  = lhs[31] ? -longint'(lhs) : longint'(lhs);
		rhs_mag  = rhs[31] ? -longint'(rhs) : longint'(rhs);
		case (op)
			CHAR_ADD: exact = longint'(lhs) + longint'(rhs);
			CHAR_SUB: exact = longint'(lhs) - longint'(rhs);
			CHAR_MUL: begin
				mag_result = (lhs_mag * rhs_mag) >> FRAC_BITS;
				exact      = negative ? -longint'(mag_result) : longint'(mag_result);
			end
			CHAR_DIV: begin
				if (rhs == 0) begin
					calc_error = STAT_DIVZERO;
					return;
				end
				mag_result = (lhs_mag << FRAC_BITS) / rhs_mag;
				exact      = negative ? -longint'(mag_result) : longint'(mag_result);
			end
			default: begin
				calc_error = STAT_ILLEGAL;
				return;
			end
		endcase
		calc_depth--;
		calc_stack[calc_depth - 1] = saturate(exact);
	endtask

	// Advances the predicted state by one accepted token and queues the result
	// of an end token.
	task automatic evaluate_token(input token_t t);
		result_t r;
		case (t.action)
			ACT_PUSH: begin
				if (calc_error == STAT_OK) begin
					if (calc_depth >= STACK_DEPTH)
						calc_error = STAT_OVERFLOW;
					else begin
						calc_stack[calc_depth] = t.number;
						calc_depth++;
					end
				end
			end
			ACT_APPLY: begin
				if (calc_error == STAT_OK)
					apply_operator(t.operator_char);
			end
			ACT_END: begin
				r.value = '0;
				if (calc_error != STAT_OK)
					r.status = calc_error;
				else if (calc_depth == 0)
					r.status = STAT_EMPTY;
				else if (calc_depth == 1) begin
					r.status = STAT_OK;
					r.value  = calc_stack[0];
				end else
					r.status = STAT_MANY;
				pending_results.push_back(r);
				calc_depth = 0;
				calc_error = STAT_OK;
			end
			default: ;
		endcase
	endtask

	// Offers one item and returns at the edge where it is taken. Valid is left
	// high so that a following item goes out back to back; whoever pauses the
	// sender lowers it.
	task automatic send_token(input action_t a, input logic signed [31:0] n,
		input logic [7:0] op);
		token_t t;
		t.action        = a;
		t.number        = n;
		t.operator_char = op;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			token_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		token_valid <= 1'b1;
		token       <= t;
		do @(posedge clk); while (!token_ready);
		evaluate_token(t);
		items_sent++;
	endtask

	// The sender stops until every predicted result has been taken. The loop waits
	// on the clock before its first check, so valid is never lowered and raised in the same step.
	task automatic wait_for_results();
		token_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic logic signed [31:0] random_operand();
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sh8000_0000;
			3, 4:    return $urandom;
			// Values within +/-16.0 keep chains of products away from the rails.
			5, 6, 7: return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
			default: return $signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
		endcase
	endfunction

	function automatic logic [7:0] random_legal_op();
		case ($urandom_range(0, 3))
			0:       return CHAR_ADD;
			1:       return CHAR_SUB;
			2:       return CHAR_MUL;
			default: return CHAR_DIV;
		endcase
	endfunction

	// One expression and its end token. Most are well formed with random
	// operands and operators; some carry a flaw (operator on an empty stack,
	// a stray character, a leftover operand, a zero divisor) and a few are
	// plain noise tokens with every action code.
	task automatic send_random_expression();
		int           shape;
		int           operands;
		int           pushes_left;
		int           ops_left;
		int           depth;
		int           flaw;
		logic [7:0]   op;
		shape = $urandom_range(0, 19);
		if (shape >= 17) begin
			repeat ($urandom_range(1, 6))
				send_token(action_t'(2'($urandom_range(0, 3))), $urandom,
					8'($urandom_range(0, 255)));
		end else begin
			operands    = ($urandom_range(0, 9) == 0) ? $urandom_range(6, STACK_DEPTH)
			                                          : $urandom_range(1, 5);
			flaw        = (shape >= 14) ? $urandom_range(1, 4) : 0;
			pushes_left = operands;
			ops_left    = operands - 1;
			depth       = 0;
			if (flaw == 1)
				send_token(ACT_APPLY, $urandom, random_legal_op());
			while (pushes_left + ops_left > 0) begin
				if (pushes_left > 0 && (depth < 2 || ops_left == 0 || $urandom_range(0, 1))) begin
					send_token(ACT_PUSH, random_operand(), 8'($urandom_range(0, 255)));
					pushes_left--;
					depth++;
				end else begin
					op = random_legal_op();
					if (flaw == 2 && $urandom_range(0, 2) == 0)
						op = 8'($urandom_range(0, 255));
					send_token(ACT_APPLY, $urandom, op);
					ops_left--;
					depth--;
				end
			end
			if (flaw == 3)
				send_token(ACT_PUSH, random_operand(), 8'($urandom_range(0, 255)));
			if (flaw == 4) begin
				send_token(ACT_PUSH, '0, 8'($urandom_range(0, 255)));
				send_token(ACT_APPLY, $urandom, CHAR_DIV);
			end
		end
		send_token(ACT_END, $urandom, 8'($urandom_range(0, 255)));
	endtask

	// Rails of the number range, every operator, the empty, zero divisor, too few
	// and illegal paths once, and the ignored action code inside a good one.
	task automatic test_directed();
		send_token(ACT_END, '0, '0);
		// Sum saturates high, then the product with the most negative value
		// saturates low.
		send_token(ACT_PUSH, 32'sh7FFF_FFFF, '0);
		send_token(ACT_PUSH, 32'sh7FFF_FFFF, '0);
		send_token(ACT_APPLY, '0, CHAR_ADD);
		send_token(ACT_PUSH, 32'sh8000_0000, '0);
		send_token(ACT_APPLY, '0, CHAR_MUL);
		send_token(ACT_END, '0, '0);
		send_token(ACT_PUSH, 32'sh8000_0000, 8'hFF);
		send_token(ACT_PUSH, 32'sh0001_0000, 8'h00);
		send_token(ACT_APPLY, 32'sh7FFF_FFFF, CHAR_SUB);
		send_token(ACT_END, 32'shFFFF_FFFF, 8'hFF);
		// 3.5 / -2.0 with an ignored token in between.
		send_token(ACT_PUSH, 32'sh0003_8000, '0);
		send_token(ACT_NONE, 32'shFFFF_FFFF, 8'hFF);
		send_token(ACT_PUSH, 32'shFFFE_0000, '0);
		send_token(ACT_APPLY, '0, CHAR_DIV);
		send_token(ACT_END, '0, '0);
		// Zero divisor; the push after it must not count.
		send_token(ACT_PUSH, 32'sh0005_0000, '0);
		send_token(ACT_PUSH, '0, '0);
		send_token(ACT_APPLY, '0, CHAR_DIV);
		send_token(ACT_PUSH, 32'sh0001_0000, '0);
		send_token(ACT_END, '0, '0);
		// A bad character with one operand reports too few operands.
		send_token(ACT_PUSH, 32'sh0001_0000, '0);
		send_token(ACT_APPLY, '0, "#");
		send_token(ACT_END, '0, '0);
		send_token(ACT_PUSH, 32'sh0001_0000, '0);
		send_token(ACT_PUSH, 32'sh0002_0000, '0);
		send_token(ACT_APPLY, '0, "=");
		send_token(ACT_END, '0, '0);
	endtask

	// Fills the stack to the brim and folds it back down, then leaves it full,
	// then pushes one too many.
	task automatic test_stack_limits();
		repeat (STACK_DEPTH)
			send_token(ACT_PUSH, random_operand(), 8'($urandom_range(0, 255)));
		repeat (STACK_DEPTH - 1)
			send_token(ACT_APPLY, $urandom, $urandom_range(0, 1) ? CHAR_ADD : CHAR_SUB);
		send_token(ACT_END, $urandom, '0);
		repeat (STACK_DEPTH)
			send_token(ACT_PUSH, random_operand(), '0);
		send_token(ACT_END, $urandom, '0);
		repeat (STACK_DEPTH + 1)
			send_token(ACT_PUSH, random_operand(), '0);
		send_token(ACT_APPLY, $urandom, CHAR_ADD);
		send_token(ACT_END, $urandom, '0);
	endtask

	// The receiver holds off for a long stretch while tokens keep coming. The
	// output register holds one result, so the second end token must wait.
	// Two bare end tokens go first so that the stall happens within the hold.
	task automatic test_output_backpressure();
		hold_left = HOLD_CYCLES;
		send_token(ACT_END, $urandom, '0);
		send_token(ACT_END, $urandom, '0);
		repeat (4)
			send_random_expression();
		wait_for_results();
	endtask

	// The bulk of the run. Idling on both sides is switched now and then, so
	// there are stretches with gaps and stretches without.
	task automatic test_random_expressions();
		int count;
		count = 0;
		while (items_sent < RANDOM_GOAL) begin
			if (count % 30 == 0) begin
				tx_idle_on = $urandom_range(0, 3) != 0;
				rx_idle_on = $urandom_range(0, 3) != 0;
			end
			send_random_expression();
			count++;
			// Now and then the sender lets everything drain first.
			if ($urandom_range(0, 49) == 0)
				wait_for_results();
		end
	endtask

	// Full rate on both channels to close the run.
	task automatic test_streaming_tail();
		int goal;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		goal = items_sent + TAIL_ITEMS;
		while (items_sent < goal)
			send_random_expression();
	endtask

	// Receiver: one assignment to ready per edge. A hold-off requested by a
	// test is counted down here; otherwise ready drops in random bursts.
	initial begin
		int burst_left;
		burst_left   = 0;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else if (!rx_idle_on)
				result_ready <= 1'b1;
			else if (burst_left > 0) begin
				result_ready <= 1'b0;
				burst_left--;
			end else if ($urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				burst_left   = $urandom_range(1, 7) - 1;
			end else
				result_ready <= 1'b1;
		end
	end

	// Every taken result is compared with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			results_checked++;
			if (pending_results.size() == 0)
				report_mismatch($sformatf("result value %0d status %0d with none predicted",
					result.value, result.status));
			else begin
				want = pending_results.pop_front();
				status_seen[want.status]++;
				if (result.status !== want.status)
					report_mismatch($sformatf("status %0d, predicted %0d",
						result.status, want.status));
				if (result.value !== want.value)
					report_mismatch($sformatf("value %0d, predicted %0d (status %0d)",
						result.value, want.value, want.status));
			end
		end
	end

	// Watchdog: any handshake restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (token_valid && token_ready) || (result_valid && result_ready))
			idle_cycles = 0;
		else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("ERROR: no handshake for %0d cycles, %0d results outstanding",
					idle_cycles, pending_results.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		token_valid    = 1'b0;
		token          = '0;
		calc_depth     = 0;
		calc_error     = STAT_OK;
		mismatch_count = 0;
		items_sent     = 0;
		results_checked = 0;
		idle_cycles    = 0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		hold_left      = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_for_results();
		test_stack_limits();
		wait_for_results();
		test_output_backpressure();
		test_random_expressions();
		test_streaming_tail();

		// Everything is sent: wait for the last results, then give a divide
		// that may still be running time to show any stray output.
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (pending_results.size() != 0) begin
			void'(pending_results.pop_front());
			report_mismatch("predicted result never arrived");
		end

		$display("Sent %0d tokens, checked %0d results (ok %0d, few %0d, div-by-zero %0d,",
			items_sent, results_checked, status_seen[STAT_OK], status_seen[STAT_FEW],
			status_seen[STAT_DIVZERO]);
		$display("  illegal %0d, too many %0d, empty %0d, overflow %0d), with output hold-off",
			status_seen[STAT_ILLEGAL], status_seen[STAT_MANY], status_seen[STAT_EMPTY],
			status_seen[STAT_OVERFLOW]);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
src/pfe_pkg.sv
src/pfe_stack_ram.sv
src/pfe_arith.sv
src/postfix_expression_evaluator.sv
src/pfe_checker.sv
verif/postfix_expression_evaluator_test.sv
